FILE: sv/bat_pkg.sv
// ----------------------------------------------------------------------------
// bat_pkg: shared types and constants for the breakpoint address table
// Sizes of the table, command codes and the controller-to-datapath bundle.
// ----------------------------------------------------------------------------
package bat_pkg;

  // table geometry
  localparam int MAX_BP = 16;
  localparam int ADDR_W = 24;
  localparam int CNT_W  = $clog2(MAX_BP + 1);
  localparam int IDX_W  = (MAX_BP > 1) ? $clog2(MAX_BP) : 1;
  localparam int CMD_W  = 3;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_CHECK  = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_COUNT  = 3'd3,
    CMD_READ   = 3'd4
  } cmd_t;

  // controller commands to the datapath
  typedef struct packed {
    logic load;   // capture the incoming beat
    logic exec;   // run the command, update table and result register
  } dp_ctl_t;

endpackage

FILE: sv/bat_ctrl.sv
// ----------------------------------------------------------------------------
// bat_ctrl: command sequencer for the breakpoint address table
// Takes one input beat, runs it through the datapath, holds the result beat.
// ----------------------------------------------------------------------------
module bat_ctrl import bat_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_ctl_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // handshake and datapath strobes
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign ctl.load  = (state_r == S_IDLE) && in_valid;
  assign ctl.exec  = (state_r == S_EXEC);

endmodule

FILE: sv/bat_dp.sv
// ----------------------------------------------------------------------------
// bat_dp: datapath of the breakpoint address table
// Cell array with parallel compare, shift-down on remove, result register.
// ----------------------------------------------------------------------------
module bat_dp import bat_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_ctl_t           ctl,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [ADDR_W-1:0] in_address,
  output logic              out_found,
  output logic [ADDR_W-1:0] out_entry_value,
  output logic [CNT_W-1:0]  out_entry_count,
  output logic              out_table_full
);

  cmd_t              cmd_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] mem_r   [MAX_BP];
  logic [ADDR_W-1:0] mem_nxt [MAX_BP];
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [MAX_BP-1:0] hit;
  logic [MAX_BP-1:0] at_or_after_hit;
  logic              any_hit;
  logic              found_r, found_nxt;
  logic [ADDR_W-1:0] value_r, value_nxt;
  logic [CNT_W-1:0]  cnt_out_r;
  logic              full_r, full_nxt;

  // capture the command beat
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= cmd_t'(in_command);
      addr_r <= in_address;
    end
  end

  // parallel compare over the valid cells
  always_comb begin
    for (int k = 0; k < MAX_BP; k++) begin
      hit[k] = (CNT_W'(k) < count_r) && (mem_r[k] == addr_r);
    end
  end

  assign any_hit = |hit;

  // cells at or above the hit move down on remove
  always_comb begin
    at_or_after_hit[0] = hit[0];
    for (int k = 1; k < MAX_BP; k++) begin
      at_or_after_hit[k] = at_or_after_hit[k-1] | hit[k];
    end
  end

  // command execution
  always_comb begin
    mem_nxt   = mem_r;
    count_nxt = count_r;
    found_nxt = 1'b0;
    value_nxt = '0;
    full_nxt  = 1'b0;
    unique case (cmd_r)
      CMD_CHECK: begin
        found_nxt = any_hit;
      end
      CMD_INSERT: begin
        found_nxt = any_hit;
        if (!any_hit) begin
          if (count_r < CNT_W'(MAX_BP)) begin
            for (int k = 0; k < MAX_BP; k++) begin
              if (CNT_W'(k) == count_r) mem_nxt[k] = addr_r;
            end
            count_nxt = count_r + 1'b1;
          end else begin
            full_nxt = 1'b1;
          end
        end
      end
      CMD_REMOVE: begin
        found_nxt = any_hit;
        if (any_hit) begin
          for (int k = 0; k < MAX_BP - 1; k++) begin
            if (at_or_after_hit[k]) mem_nxt[k] = mem_r[k+1];
          end
          count_nxt = count_r - 1'b1;
        end
      end
      CMD_COUNT: begin
      end
      CMD_READ: begin
        // full index compared against the count
        if (addr_r < {{(ADDR_W-CNT_W){1'b0}}, count_r}) begin
          value_nxt = mem_r[addr_r[IDX_W-1:0]];
        end
      end
      default: begin
      end
    endcase
  end

  // table cells, no reset
  always_ff @(posedge clk) begin
    if (ctl.exec) mem_r <= mem_nxt;
  end

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n)        count_r <= '0;
    else if (ctl.exec) count_r <= count_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      found_r   <= found_nxt;
      value_r   <= value_nxt;
      cnt_out_r <= count_nxt;
      full_r    <= full_nxt;
    end
  end

  assign out_found       = found_r;
  assign out_entry_value = value_r;
  assign out_entry_count = cnt_out_r;
  assign out_table_full  = full_r;

endmodule

FILE: sv/breakpoint_address_table.sv
// ----------------------------------------------------------------------------
// breakpoint_address_table: top level of the breakpoint address table
// Ordered table of breakpoint addresses with check/insert/remove/count/read.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  input    | in_valid / in_stall | in_command, in_address
//  result   | out_valid/out_stall | out_found, out_entry_value,
//           |                     | out_entry_count, out_table_full
//
//  A command passes accept (idle), execute (compare and table update),
//  present, and waits out any output stall. out_valid rises as the
//  sequencer leaves execute and holds through any output stall.
//  The controller sequence sets this; one command is in flight at a time.
//  Reset (rst_n low, synchronous) empties the table; no clearing pass.
//  in_stall is high from accept until the result beat is taken.
// ----------------------------------------------------------------------------
module breakpoint_address_table import bat_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [ADDR_W-1:0] in_address,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_found,
  output logic [ADDR_W-1:0] out_entry_value,
  output logic [CNT_W-1:0]  out_entry_count,
  output logic              out_table_full
);

  dp_ctl_t ctl;

  // sequencer
  bat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  // table and result datapath
  bat_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .in_command      (in_command),
    .in_address      (in_address),
    .out_found       (out_found),
    .out_entry_value (out_entry_value),
    .out_entry_count (out_entry_count),
    .out_table_full  (out_table_full)
  );

endmodule
